### design/dsfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfm_pkg
// Shared types and codes for the distance sensor frame monitor.
// ----------------------------------------------------------------------------
package dsfm_pkg;

  // Event codes carried in the mode field
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;
  localparam logic [1:0] MODE_RESET = 2'd3;

  // Sensor health codes
  localparam logic [1:0] HEALTH_OK      = 2'd0;
  localparam logic [1:0] HEALTH_FAILING = 2'd1;
  localparam logic [1:0] HEALTH_DEAD    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FAIL_LIMIT = 2'd0;
  localparam logic [1:0] REG_NEAR_THR   = 2'd1;
  localparam logic [1:0] REG_HOLD_TICKS = 2'd2;
  localparam logic [1:0] REG_RETRY      = 2'd3;

  localparam int unsigned CM_W       = 13;

  localparam logic [7:0]  SYNC_BYTE = 8'hFF;
  localparam logic [15:0] MIN_MM    = 16'd10;
  localparam logic [16:0] ROUND_MM  = 17'd5;
  // floor(x / 10) == (x * 52429) >> 19 for all x below 2^17
  localparam logic [15:0] RECIP_10  = 16'd52429;
  localparam int unsigned RECIP_SH  = 19;
  localparam logic [15:0] TICK_MAX  = 16'hFFFF;
  localparam logic [7:0]  FAIL_MAX  = 8'hFF;

  // Latched frame as seen by the presence logic
  typedef struct packed {
    logic            found;
    logic            dist_ok;   // distance at least MIN_MM
    logic [CM_W-1:0] cm;
  } frame_t;

  // One result beat
  typedef struct packed {
    logic            answered;
    logic            near;
    logic            distance_valid;
    logic [CM_W-1:0] distance_cm;
    logic [1:0]      health;
    logic            retry_due;
  } result_t;

endpackage

### design/dsfm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfm_in_if
// Event channel: valid/ready with mode and received byte.
// ----------------------------------------------------------------------------
interface dsfm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

### design/dsfm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfm_out_if
// Result channel: valid/ready with the monitor's report fields.
// ----------------------------------------------------------------------------
interface dsfm_out_if;
  logic        valid;
  logic        ready;
  logic        answered;
  logic        near;
  logic        distance_valid;
  logic [12:0] distance_cm;
  logic [1:0]  health;
  logic        retry_due;

  modport source (output valid, output answered, output near, output distance_valid,
                  output distance_cm, output health, output retry_due, input ready);
  modport sink   (input valid, input answered, input near, input distance_valid,
                  input distance_cm, input health, input retry_due, output ready);
endinterface

### design/dsfm_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfm_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface dsfm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/dsfm_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfm_frame_parser
// Sliding 0xFF/high/low/sum frame check over the first bytes of a window.
// ----------------------------------------------------------------------------
module dsfm_frame_parser
  import dsfm_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [1:0] mode,
  input  logic [7:0] rx_byte,
  output frame_t     frame
);

  localparam int unsigned CNT_W = $clog2(WINDOW_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(WINDOW_BYTES);
  localparam logic [CNT_W-1:0] CNT_THIRD = CNT_W'(3);

  logic [7:0]       b0_r, b1_r, b2_r;
  logic [CNT_W-1:0] count_r;
  logic             found_r;
  logic             dist_ok_r;
  logic [CM_W-1:0]  cm_r;

  logic [15:0] mm;
  logic [16:0] mm_rnd;
  logic [32:0] prod;
  logic [7:0]  sum;
  logic        take;
  logic        hit;

  assign mm     = {b1_r, b2_r};
  assign mm_rnd = {1'b0, mm} + ROUND_MM;
  assign prod   = 33'(mm_rnd) * 33'(RECIP_10);
  assign sum    = SYNC_BYTE + b1_r + b2_r;
  assign take   = step && (mode == MODE_BYTE) && (count_r < CNT_LAST);
  assign hit    = !found_r && (count_r >= CNT_THIRD) && (b0_r == SYNC_BYTE) &&
                  (sum == rx_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r    <= '0;
      b1_r    <= '0;
      b2_r    <= '0;
      count_r <= '0;
      found_r <= 1'b0;
    end else if (step && (mode == MODE_END)) begin
      // drop the window
      b0_r    <= '0;
      b1_r    <= '0;
      b2_r    <= '0;
      count_r <= '0;
      found_r <= 1'b0;
    end else if (take) begin
      b0_r    <= b1_r;
      b1_r    <= b2_r;
      b2_r    <= rx_byte;
      count_r <= count_r + 1'b1;
      if (hit) begin
        found_r <= 1'b1;
      end
    end
  end

  // latched distance, converted to centimetres at latch time
  always_ff @(posedge clk) begin
    if (take && hit) begin
      dist_ok_r <= (mm >= MIN_MM);
      cm_r      <= prod[RECIP_SH +: CM_W];
    end
  end

  assign frame.found   = found_r;
  assign frame.dist_ok = dist_ok_r;
  assign frame.cm      = cm_r;

endmodule

### design/dsfm_presence.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfm_presence
// Health, hold and dead-time state; forms the result for each event.
// ----------------------------------------------------------------------------
module dsfm_presence
  import dsfm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [1:0]      mode,
  input  frame_t          frame,
  input  logic [7:0]      fail_limit,
  input  logic [CM_W-1:0] near_thr,
  input  logic [15:0]     hold_ticks,
  input  logic [15:0]     retry_ticks,
  output result_t         result
);

  logic [7:0]  fail_cnt_r, fail_cnt_nxt;
  logic [1:0]  health_r, health_nxt;
  logic        holding_r, holding_nxt;
  logic [15:0] hold_el_r, hold_el_nxt;
  logic [15:0] dead_el_r, dead_el_nxt;
  logic [7:0]  fail_inc;

  assign fail_inc = (fail_cnt_r < FAIL_MAX) ? fail_cnt_r + 1'b1 : fail_cnt_r;

  always_comb begin
    fail_cnt_nxt = fail_cnt_r;
    health_nxt   = health_r;
    holding_nxt  = holding_r;
    hold_el_nxt  = hold_el_r;
    dead_el_nxt  = dead_el_r;
    result       = '0;
    case (mode)
      MODE_TICK: begin
        if (holding_r && hold_el_r < TICK_MAX) begin
          hold_el_nxt = hold_el_r + 1'b1;
        end
        if (health_r == HEALTH_DEAD && dead_el_r < TICK_MAX) begin
          dead_el_nxt = dead_el_r + 1'b1;
        end
      end
      MODE_END: begin
        result.answered = 1'b1;
        if (health_r == HEALTH_DEAD) begin
          holding_nxt = 1'b0;
        end else if (holding_r && hold_el_r < hold_ticks) begin
          result.near = 1'b1;
        end else begin
          holding_nxt = 1'b0;
          if (!frame.found) begin
            fail_cnt_nxt = fail_inc;
            if (fail_inc >= fail_limit) begin
              // entering dead from a live state
              dead_el_nxt = '0;
              health_nxt  = HEALTH_DEAD;
            end else begin
              health_nxt = HEALTH_FAILING;
            end
          end else begin
            fail_cnt_nxt = '0;
            health_nxt   = HEALTH_OK;
            if (frame.dist_ok) begin
              result.distance_valid = 1'b1;
              result.distance_cm    = frame.cm;
              if (frame.cm < near_thr) begin
                hold_el_nxt = '0;
                holding_nxt = 1'b1;
                result.near = 1'b1;
              end
            end
          end
        end
      end
      MODE_RESET: begin
        fail_cnt_nxt = '0;
        health_nxt   = HEALTH_OK;
        dead_el_nxt  = '0;
        holding_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
    result.health    = health_nxt;
    result.retry_due = (health_nxt == HEALTH_DEAD) && (retry_ticks != '0) &&
                       (dead_el_nxt >= retry_ticks);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_cnt_r <= '0;
      health_r   <= HEALTH_OK;
      holding_r  <= 1'b0;
      hold_el_r  <= '0;
      dead_el_r  <= '0;
    end else if (step) begin
      fail_cnt_r <= fail_cnt_nxt;
      health_r   <= health_nxt;
      holding_r  <= holding_nxt;
      hold_el_r  <= hold_el_nxt;
      dead_el_r  <= dead_el_nxt;
    end
  end

endmodule

### design/distance_sensor_frame_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_sensor_frame_monitor
// Parses ultrasonic sensor frames per window and reports presence and health.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  : one event per beat - tick, received byte, window end or health
//             reset (mode), with the byte in rx_byte.
//   out_bus : exactly one result beat per event; answered marks window ends.
//   cfg_bus : register writes (fail limit, near threshold, hold ticks, retry
//             ticks), always ready; write only while the block is idle.
// Flow: an accepted event is captured in the input register, handled from
//   there into the result register and presented on out_bus.
// Throughput: one event per cycle unless out_bus stalls, set by the single
//   registered parser and presence update between input and result registers.
// Stall: while out_bus is held off the result register keeps its beat; the
//   input register still takes one more event, after which in_bus.ready
//   falls until the result is taken.
// Reset: rst_n (synchronous, active low) empties both registers, clears the
//   window, health to ok, hold and dead timers to zero and loads the
//   register defaults 3, 100, 1000 and 5000.
// ----------------------------------------------------------------------------
module distance_sensor_frame_monitor
  import dsfm_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  dsfm_in_if.sink     in_bus,
  dsfm_out_if.source  out_bus,
  dsfm_cfg_if.sink    cfg_bus
);

  // configuration registers
  logic [7:0]      fail_limit_r;
  logic [CM_W-1:0] near_thr_r;
  logic [15:0]     hold_ticks_r;
  logic [15:0]     retry_ticks_r;

  // input register
  logic       in_v_r;
  logic [1:0] in_mode_r;
  logic [7:0] in_byte_r;

  // result register
  logic    out_v_r;
  result_t res_r;

  logic    adv;    // result register free for a new beat
  logic    step;   // the held event is processed this cycle
  frame_t  frame;
  result_t res_nxt;

  assign adv  = !out_v_r || out_bus.ready;
  assign step = in_v_r && adv;

  assign in_bus.ready  = !in_v_r || adv;
  assign cfg_bus.ready = 1'b1;

  // Configuration writes: truncate the data to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_limit_r  <= 8'd3;
      near_thr_r    <= 13'd100;
      hold_ticks_r  <= 16'd1000;
      retry_ticks_r <= 16'd5000;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_FAIL_LIMIT: fail_limit_r  <= cfg_bus.data[7:0];
        REG_NEAR_THR:   near_thr_r    <= cfg_bus.data[CM_W-1:0];
        REG_HOLD_TICKS: hold_ticks_r  <= cfg_bus.data;
        REG_RETRY:      retry_ticks_r <= cfg_bus.data;
        default: begin
        end
      endcase
    end
  end

  // Input register: load on every accepted beat, empty once processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      in_v_r <= 1'b1;
    end else if (step) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_mode_r <= in_bus.mode;
      in_byte_r <= in_bus.rx_byte;
    end
  end

  dsfm_frame_parser #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .mode    (in_mode_r),
    .rx_byte (in_byte_r),
    .frame   (frame)
  );

  dsfm_presence u_presence (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .mode        (in_mode_r),
    .frame       (frame),
    .fail_limit  (fail_limit_r),
    .near_thr    (near_thr_r),
    .hold_ticks  (hold_ticks_r),
    .retry_ticks (retry_ticks_r),
    .result      (res_nxt)
  );

  // Result register: advance on a processed event, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid          = out_v_r;
  assign out_bus.answered       = res_r.answered;
  assign out_bus.near           = res_r.near;
  assign out_bus.distance_valid = res_r.distance_valid;
  assign out_bus.distance_cm    = res_r.distance_cm;
  assign out_bus.health         = res_r.health;
  assign out_bus.retry_due      = res_r.retry_due;

`ifndef SYNTHESIS
  // Only window ends report presence or a distance
  a_answer_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !res_r.answered |-> !res_r.near && !res_r.distance_valid)
    else $error("presence reported on a non window-end beat");

  // No distance without a valid reading
  a_cm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !res_r.distance_valid |-> res_r.distance_cm == '0)
    else $error("distance driven without a valid reading");

  // Retry only ever flagged while dead
  a_retry_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.retry_due |-> res_r.health == HEALTH_DEAD)
    else $error("retry due outside dead state");

  // A held event is not lost while the result side is stalled
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(in_mode_r) && $stable(in_byte_r))
    else $error("held event changed under stall");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the distance sensor frame monitor: a directed table
// of events, then randomised windows, frames, ticks and health resets under
// several register settings, each beat checked against its table row or predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import dsfm_pkg::*;

  localparam int unsigned WINDOW_BYTES     = 16;
  localparam int unsigned RANDOM_PER_PHASE = 180;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned DRAIN_CYCLES     = 16;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned PRINT_CAP        = 40;

  // One row of the directed table; want is only used when typed is set
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam int DIRECTED_N = 25;

  // Defaults after reset: fail limit 3, threshold 100 cm, hold 1000, retry 5000
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // quiet tick straight after reset
    '{MODE_TICK,  8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 13'd0,    HEALTH_OK,      1'b0}},
    // empty window: first failure
    '{MODE_END,   8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 13'd0,    HEALTH_FAILING, 1'b0}},
    // 5 mm frame: parsed, health back to ok, but too close to report
    '{MODE_BYTE,  8'hFF, 1'b0, '0},
    '{MODE_BYTE,  8'h00, 1'b0, '0},
    '{MODE_BYTE,  8'h05, 1'b0, '0},
    '{MODE_BYTE,  8'h04, 1'b0, '0},
    '{MODE_END,   8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 13'd0,    HEALTH_OK,      1'b0}},
    // largest distance, 65535 mm rounds to 6554 cm, far
    '{MODE_BYTE,  8'hFF, 1'b0, '0},
    '{MODE_BYTE,  8'hFF, 1'b0, '0},
    '{MODE_BYTE,  8'hFF, 1'b0, '0},
    '{MODE_BYTE,  8'hFD, 1'b0, '0},
    '{MODE_END,   8'hFF, 1'b1, '{1'b1, 1'b0, 1'b1, 13'd6554, HEALTH_OK,      1'b0}},
    // 15 mm rounds half up to 2 cm: near, hold starts
    '{MODE_BYTE,  8'hFF, 1'b0, '0},
    '{MODE_BYTE,  8'h00, 1'b0, '0},
    '{MODE_BYTE,  8'h0F, 1'b0, '0},
    '{MODE_BYTE,  8'h0E, 1'b0, '0},
    '{MODE_END,   8'h00, 1'b1, '{1'b1, 1'b1, 1'b1, 13'd2,    HEALTH_OK,      1'b0}},
    // live hold answers near without measuring
    '{MODE_END,   8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 13'd0,    HEALTH_OK,      1'b0}},
    // health reset drops the hold
    '{MODE_RESET, 8'hAA, 1'b1, '{1'b0, 1'b0, 1'b0, 13'd0,    HEALTH_OK,      1'b0}},
    // three empty windows take the sensor dead
    '{MODE_END,   8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 13'd0,    HEALTH_FAILING, 1'b0}},
    '{MODE_END,   8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 13'd0,    HEALTH_FAILING, 1'b0}},
    '{MODE_END,   8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 13'd0,    HEALTH_DEAD,    1'b0}},
    // window end while dead
    '{MODE_END,   8'h55, 1'b1, '{1'b1, 1'b0, 1'b0, 13'd0,    HEALTH_DEAD,    1'b0}},
    '{MODE_TICK,  8'h55, 1'b1, '{1'b0, 1'b0, 1'b0, 13'd0,    HEALTH_DEAD,    1'b0}},
    '{MODE_RESET, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b0, 13'd0,    HEALTH_OK,      1'b0}}
  };

  logic clk;
  logic rst_n;

  dsfm_in_if  in_bus ();
  dsfm_out_if out_bus ();
  dsfm_cfg_if cfg_bus ();

  distance_sensor_frame_monitor #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a mirror of the monitor's registers and configuration
  // --------------------------------------------------------------------------
  logic [7:0]  mon_fail_limit;
  logic [12:0] mon_near_thr;
  logic [15:0] mon_hold_ticks;
  logic [15:0] mon_retry_ticks;

  logic [7:0]  mon_fail_count;
  logic [1:0]  mon_health;
  logic        mon_holding;
  logic [15:0] mon_hold_elapsed;
  logic [15:0] mon_dead_elapsed;
  logic [7:0]  mon_recent [3];
  logic [8:0]  mon_win_count;
  logic        mon_frame_found;
  logic [15:0] mon_found_mm;

  // Reports still owed by the block, oldest first
  result_t expected_reports [$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned reports_checked;
  int unsigned events_counted;
  int unsigned windows_answered;
  int unsigned near_reports;
  int unsigned distance_reports;
  int unsigned dead_reports;
  int unsigned retry_reports;
  int unsigned burst_left;

  logic [1:0]  stall_style;
  int unsigned stall_left;

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               expected_reports.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predict the report for one event and advance the mirrored state
  // --------------------------------------------------------------------------
  function automatic result_t advance_monitor(input logic [1:0] mode, input logic [7:0] rx);
    result_t     r;
    logic        measure;
    logic [7:0]  sum8;
    logic [16:0] cm;
    r = '0;
    case (mode)
      MODE_TICK: begin
        if (mon_holding && mon_hold_elapsed != TICK_MAX)
          mon_hold_elapsed = mon_hold_elapsed + 16'd1;
        if (mon_health == HEALTH_DEAD && mon_dead_elapsed != TICK_MAX)
          mon_dead_elapsed = mon_dead_elapsed + 16'd1;
      end
      MODE_BYTE: begin
        // bytes past the window limit leave no trace at all
        if (mon_win_count < WINDOW_BYTES) begin
          mon_win_count = mon_win_count + 9'd1;
          sum8 = SYNC_BYTE + mon_recent[1] + mon_recent[2];
          if (!mon_frame_found && mon_win_count >= 9'd4 && mon_recent[0] == SYNC_BYTE &&
              sum8 == rx) begin
            mon_frame_found = 1'b1;
            mon_found_mm    = {mon_recent[1], mon_recent[2]};
          end
          mon_recent[0] = mon_recent[1];
          mon_recent[1] = mon_recent[2];
          mon_recent[2] = rx;
        end
      end
      MODE_END: begin
        r.answered = 1'b1;
        measure    = 1'b1;
        if (mon_health == HEALTH_DEAD) begin
          mon_holding = 1'b0;
          measure     = 1'b0;
        end else if (mon_holding) begin
          if (mon_hold_elapsed < mon_hold_ticks) begin
            r.near  = 1'b1;
            measure = 1'b0;
          end else begin
            mon_holding = 1'b0;
          end
        end
        if (measure) begin
          if (!mon_frame_found) begin
            if (mon_fail_count != FAIL_MAX)
              mon_fail_count = mon_fail_count + 8'd1;
            if (mon_fail_count >= mon_fail_limit) begin
              // not dead on entry to this branch, so the dead timer restarts
              mon_dead_elapsed = 16'd0;
              mon_health       = HEALTH_DEAD;
            end else begin
              mon_health = HEALTH_FAILING;
            end
          end else begin
            mon_fail_count = 8'd0;
            mon_health     = HEALTH_OK;
            if (mon_found_mm >= MIN_MM) begin
              cm = (17'(mon_found_mm) + 17'd5) / 17'd10;
              r.distance_valid = 1'b1;
              r.distance_cm    = cm[CM_W-1:0];
              if (cm < 17'(mon_near_thr)) begin
                mon_hold_elapsed = 16'd0;
                mon_holding      = 1'b1;
                r.near           = 1'b1;
              end
            end
          end
        end
        // every window end empties the window
        mon_recent[0]   = 8'd0;
        mon_recent[1]   = 8'd0;
        mon_recent[2]   = 8'd0;
        mon_win_count   = 9'd0;
        mon_frame_found = 1'b0;
      end
      default: begin
        mon_fail_count   = 8'd0;
        mon_health       = HEALTH_OK;
        mon_dead_elapsed = 16'd0;
        mon_holding      = 1'b0;
      end
    endcase
    r.health    = mon_health;
    r.retry_due = (mon_health == HEALTH_DEAD && mon_retry_ticks != 16'd0 &&
                   mon_dead_elapsed >= mon_retry_ticks);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Event sender: bursts of beats with random gaps between them
  // --------------------------------------------------------------------------
  task automatic push_event(input logic [1:0] mode, input logic [7:0] rx,
                            input logic typed = 1'b0, input result_t typed_report = '0);
    result_t predicted;
    in_bus.valid   <= 1'b1;
    in_bus.mode    <= mode;
    in_bus.rx_byte <= rx;
    do @(posedge clk); while (!in_bus.ready);
    predicted = advance_monitor(mode, rx);
    // table rows with a typed report are held to it, the rest to the predictor
    expected_reports.push_back(typed ? typed_report : predicted);
    events_counted++;
    if (predicted.answered)
      windows_answered++;
    if (predicted.near)
      near_reports++;
    if (predicted.distance_valid)
      distance_reports++;
    if (predicted.health == HEALTH_DEAD)
      dead_reports++;
    if (predicted.retry_due)
      retry_reports++;
    // keep valid high inside a burst; drop it only for a gap
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 20);
    end
  endtask

  // Received byte, now and then with a tick slipped in ahead of it
  task automatic send_rx(input logic [7:0] b);
    if ($urandom_range(0, 9) == 0)
      push_event(MODE_TICK, 8'($urandom_range(0, 255)));
    push_event(MODE_BYTE, b);
  endtask

  // Distance in mm, biased towards the interesting edges
  function automatic logic [15:0] pick_distance();
    int v;
    int thr_mm;
    thr_mm = 10 * int'(mon_near_thr);
    case ($urandom_range(0, 4))
      0: v = int'($urandom_range(0, 9));
      1: v = int'($urandom_range(10, thr_mm + 30));
      2: v = 10 * int'($urandom_range(1, 6553)) + 5 - int'($urandom_range(0, 1));
      3: v = int'($urandom_range(0, 65535));
      default: v = thr_mm - int'($urandom_range(4, 7));
    endcase
    if (v < 0)
      v = 0;
    if (v > 65535)
      v = 65535;
    return 16'(v);
  endfunction

  // One window: noise, a frame (checksum broken on request), more bytes, end
  task automatic send_window(input logic corrupt);
    logic [15:0] mm;
    logic [7:0]  chk;
    int unsigned lead;
    int unsigned trail;
    mm  = pick_distance();
    chk = SYNC_BYTE + mm[15:8] + mm[7:0];
    if (corrupt)
      chk = chk ^ 8'($urandom_range(1, 255));
    // long lead-ins push the frame partly or wholly past the window limit
    lead  = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
    trail = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 2);
    repeat (lead) send_rx(8'($urandom_range(0, 255)));
    send_rx(SYNC_BYTE);
    send_rx(mm[15:8]);
    send_rx(mm[7:0]);
    send_rx(chk);
    repeat (trail) send_rx(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 30)) push_event(MODE_TICK, 8'($urandom_range(0, 255)));
    push_event(MODE_END, 8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Register writes: one beat each, valid held across a group
  // --------------------------------------------------------------------------
  task automatic cfg_beat(input logic [1:0] index, input logic [15:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (index)
      REG_FAIL_LIMIT: mon_fail_limit  = data[7:0];
      REG_NEAR_THR:   mon_near_thr    = data[CM_W-1:0];
      REG_HOLD_TICKS: mon_hold_ticks  = data;
      default:        mon_retry_ticks = data;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] limit, input logic [12:0] thr,
                                input logic [15:0] hold, input logic [15:0] retry);
    // stop sending, let every owed report drain, then let the pipe settle
    in_bus.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_beat(REG_FAIL_LIMIT, 16'(limit));
    cfg_beat(REG_NEAR_THR, 16'(thr));
    cfg_beat(REG_HOLD_TICKS, hold);
    cfg_beat(REG_RETRY, retry);
    cfg_bus.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at report %0d: %s", reports_checked, msg);
    mismatch_count++;
  endtask

  task automatic match_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want)
      report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  task automatic check_beat();
    result_t got;
    result_t want;
    got.answered       = out_bus.answered;
    got.near           = out_bus.near;
    got.distance_valid = out_bus.distance_valid;
    got.distance_cm    = out_bus.distance_cm;
    got.health         = out_bus.health;
    got.retry_due      = out_bus.retry_due;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing owed (health %0d)", got.health));
    end else begin
      want = expected_reports.pop_front();
      reports_checked++;
      match_field("answered", 16'(want.answered), 16'(got.answered));
      match_field("near", 16'(want.near), 16'(got.near));
      match_field("distance_valid", 16'(want.distance_valid), 16'(got.distance_valid));
      match_field("distance_cm", 16'(want.distance_cm), 16'(got.distance_cm));
      match_field("health", 16'(want.health), 16'(got.health));
      match_field("retry_due", 16'(want.retry_due), 16'(got.retry_due));
    end
  endtask

  // Receiver: take beats, and hold off in one of several randomly switched styles
  // (always ready, random, periodic, mostly stalled)
  always @(posedge clk) begin
    logic take;
    if (rst_n && out_bus.valid && out_bus.ready)
      check_beat();
    if (stall_left == 0) begin
      stall_style <= 2'($urandom_range(0, 3));
      stall_left  <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      2'd0:    take = 1'b1;
      2'd1:    take = ($urandom_range(0, 2) != 0);
      2'd2:    take = ((cycle_count % 5) >= 2);
      default: take = ($urandom_range(0, 7) == 0);
    endcase
    out_bus.ready <= take;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_start;
    stim_row_t   row;

    // drive every input to a known value from time zero
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.mode     = MODE_TICK;
    in_bus.rx_byte  = 8'd0;
    out_bus.ready   = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = REG_FAIL_LIMIT;
    cfg_bus.data    = 16'd0;
    cycle_count     = 0;
    mismatch_count  = 0;
    reports_checked = 0;
    events_counted  = 0;
    windows_answered = 0;
    near_reports    = 0;
    distance_reports = 0;
    dead_reports    = 0;
    retry_reports   = 0;
    burst_left      = 4;
    stall_style     = 2'd0;
    stall_left      = 0;

    // mirror the reset defaults
    mon_fail_limit   = 8'd3;
    mon_near_thr     = 13'd100;
    mon_hold_ticks   = 16'd1000;
    mon_retry_ticks  = 16'd5000;
    mon_fail_count   = 8'd0;
    mon_health       = HEALTH_OK;
    mon_holding      = 1'b0;
    mon_hold_elapsed = 16'd0;
    mon_dead_elapsed = 16'd0;
    mon_recent[0]    = 8'd0;
    mon_recent[1]    = 8'd0;
    mon_recent[2]    = 8'd0;
    mon_win_count    = 9'd0;
    mon_frame_found  = 1'b0;
    mon_found_mm     = 16'd0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table under the reset defaults
    for (int i = 0; i < DIRECTED_N; i++) begin
      row = DIRECTED_ROWS[i];
      push_event(row.mode, row.rx_byte, row.typed, row.want);
    end

    // random part: one register setting per phase, extremes included
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: apply_settings(8'd3, 13'd100, 16'd20, 16'd30);
        1: apply_settings(8'd0, 13'd0, 16'd0, 16'd0);
        2: apply_settings(8'd255, 13'd6554, 16'd5, 16'd1);
        3: apply_settings(8'($urandom_range(1, 4)), 13'($urandom_range(0, 6554)),
                          16'($urandom_range(0, 40)), 16'($urandom_range(0, 60)));
        default: apply_settings(8'd2, 13'd6554, 16'hFFFF, 16'hFFFF);
      endcase
      phase_start = events_counted;
      while (events_counted - phase_start < RANDOM_PER_PHASE) begin
        case ($urandom_range(0, 99)) inside
          [0:59]:  send_window(1'b0);
          [60:69]: send_window(1'b1);
          [70:79]: repeat ($urandom_range(1, 48))
                     push_event(MODE_TICK, 8'($urandom_range(0, 255)));
          [80:87]: push_event(MODE_END, 8'($urandom_range(0, 255)));
          [88:93]: push_event(MODE_RESET, 8'($urandom_range(0, 255)));
          default: repeat ($urandom_range(1, 8))
                     push_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        endcase
      end
    end

    // drain: wait for every owed report, then watch for strays
    in_bus.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d events, %0d reports checked: %0d window ends, %0d near, %0d distances",
             events_counted, reports_checked, windows_answered, near_reports,
             distance_reports);
    $display("dead reported %0d times, retry due %0d times, over five register settings",
             dead_reports, retry_reports);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### distance_sensor_frame_monitor.f
design/dsfm_pkg.sv
design/dsfm_in_if.sv
design/dsfm_out_if.sv
design/dsfm_cfg_if.sv
design/dsfm_frame_parser.sv
design/dsfm_presence.sv
design/distance_sensor_frame_monitor.sv
sim/tb_top.sv
